// ===== rtl/efd_pkg.sv =====
package efd_pkg;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_TRUNC = 2'd1;
  localparam logic [1:0] ST_LONG  = 2'd2;

  // register indexes on the apb port
  localparam logic REG_RANGE_TYPE  = 1'b0;
  localparam logic REG_MAX_PAYLOAD = 1'b1;

  localparam int AddrWidth = 3;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] timestamp;
    logic [7:0]  event_type;
    logic [15:0] range_value;
    logic [7:0]  range_count;
  } efd_result_t;

endpackage

// ===== rtl/efd_cfg_regs.sv =====
module efd_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [efd_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic [7:0]                    range_type,
  output logic [7:0]                    max_payload
);

  logic wr_en;
  logic reg_sel;

  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      range_type  <= 8'd1;
      max_payload <= 8'd12;
    end else if (wr_en) begin
      case (reg_sel)
        efd_pkg::REG_RANGE_TYPE:  range_type  <= pwdata[7:0];
        efd_pkg::REG_MAX_PAYLOAD: max_payload <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      efd_pkg::REG_RANGE_TYPE:  prdata = {24'd0, range_type};
      efd_pkg::REG_MAX_PAYLOAD: prdata = {24'd0, max_payload};
      default:                  prdata = 32'd0;
    endcase
  end

endmodule

// ===== rtl/efd_decode.sv =====
module efd_decode (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           data_byte,
  input  logic [7:0]           range_type,
  input  logic [7:0]           max_payload,
  output logic                 emit,
  output efd_pkg::efd_result_t result
);

  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;

  localparam logic [7:0] SYNC_BYTE     = 8'h45;
  localparam logic [7:0] TYPE_POS      = 8'd4;
  localparam logic [7:0] RANGE_LO_POS  = 8'd5;
  localparam logic [7:0] RANGE_HI_POS  = 8'd6;
  localparam logic [7:0] COUNT_POS     = 8'd7;
  localparam logic [7:0] MIN_PLAIN_LEN = 8'd5;
  localparam logic [7:0] MIN_RANGE_LEN = 8'd8;

  logic [1:0]  phase, phase_next;
  logic [7:0]  frame_length, frame_length_next;
  logic [7:0]  byte_position, byte_position_next;
  logic [31:0] stamp_acc, stamp_acc_next;
  logic [7:0]  type_reg, type_reg_next;
  logic [15:0] range_acc, range_acc_next;
  logic [7:0]  count_reg, count_reg_next;
  logic        is_range;

  always_comb begin
    phase_next         = phase;
    frame_length_next  = frame_length;
    byte_position_next = byte_position;
    stamp_acc_next     = stamp_acc;
    type_reg_next      = type_reg;
    range_acc_next     = range_acc;
    count_reg_next     = count_reg;
    emit               = 1'b0;
    result             = '0;
    is_range           = 1'b0;

    case (phase)
      PH_LEN: begin
        if (data_byte > max_payload) begin
          phase_next    = PH_HUNT;
          emit          = 1'b1;
          result.status = efd_pkg::ST_LONG;
        end else if (data_byte == 8'd0) begin
          phase_next    = PH_HUNT;
          emit          = 1'b1;
          result.status = efd_pkg::ST_TRUNC;
        end else begin
          frame_length_next  = data_byte;
          byte_position_next = 8'd0;
          stamp_acc_next     = 32'd0;
          type_reg_next      = 8'd0;
          range_acc_next     = 16'd0;
          count_reg_next     = 8'd0;
          phase_next         = PH_DATA;
        end
      end

      PH_DATA: begin
        // field capture by byte position
        if (byte_position < TYPE_POS) begin
          stamp_acc_next[{byte_position[1:0], 3'b000} +: 8] = data_byte;
        end else if (byte_position == TYPE_POS) begin
          type_reg_next = data_byte;
        end else if (type_reg == range_type) begin
          if (byte_position == RANGE_LO_POS) begin
            range_acc_next[7:0] = data_byte;
          end else if (byte_position == RANGE_HI_POS) begin
            range_acc_next[15:8] = data_byte;
          end else if (byte_position == COUNT_POS) begin
            count_reg_next = data_byte;
          end
        end
        byte_position_next = byte_position + 8'd1;

        // end of frame
        is_range = (type_reg_next == range_type);
        if (byte_position_next == frame_length) begin
          phase_next = PH_HUNT;
          emit       = 1'b1;
          if (frame_length < MIN_PLAIN_LEN || (is_range && frame_length < MIN_RANGE_LEN)) begin
            result.status = efd_pkg::ST_TRUNC;
          end else begin
            result.status     = efd_pkg::ST_OK;
            result.timestamp  = stamp_acc_next;
            result.event_type = type_reg_next;
            if (is_range) begin
              result.range_value = range_acc_next;
              result.range_count = count_reg_next;
            end
          end
        end
      end

      default: begin
        phase_next = (data_byte == SYNC_BYTE) ? PH_LEN : PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
    end else if (step) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      frame_length  <= frame_length_next;
      byte_position <= byte_position_next;
      stamp_acc     <= stamp_acc_next;
      type_reg      <= type_reg_next;
      range_acc     <= range_acc_next;
      count_reg     <= count_reg_next;
    end
  end

endmodule

// ===== rtl/efd_out_reg.sv =====
module efd_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  efd_pkg::efd_result_t load_data,
  input  logic                 out_ready,
  output logic                 out_valid,
  output efd_pkg::efd_result_t out_data
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= load_data;
    end
  end

endmodule

// ===== rtl/event_frame_deframer_top.sv =====
// event frame deframer: takes one received byte per item, hunts for the sync
// byte 0x45 ('E'), then reads a length byte and that many payload bytes,
// decoding a little-endian 32-bit timestamp, an event type and, when the
// type equals range_type, a 16-bit range and an 8-bit count. one result item
// comes out per frame: status ok, truncated (also for a zero length) or too
// long (length above max_payload, reported right after the length byte).
// throughput is one byte per clock while results can leave: a byte sits in the
// input register while the decoder updates the frame state, and a result it
// makes is loaded into the output register as the byte that ends its frame
// leaves the input register, unless a stall holds it. input ready drops only
// when the held byte would produce a result while the output register is
// still full and not being taken. registers: range_type at 0x0 (reset 1),
// max_payload at 0x4 (reset 12); write them only while the block is idle.
module event_frame_deframer_top (
  input  logic                          clk,
  input  logic                          rst,

  // byte input
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_byte,

  // result output
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    status,
  output logic [31:0]                   timestamp,
  output logic [7:0]                    event_type,
  output logic [15:0]                   range_value,
  output logic [7:0]                    range_count,

  // apb config port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [efd_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic                 hold_valid;
  logic [7:0]           hold_byte;
  logic                 advance;
  logic                 emit;
  logic [7:0]           range_type;
  logic [7:0]           max_payload;
  efd_pkg::efd_result_t result;
  efd_pkg::efd_result_t out_data;

  assign pready = 1'b1;

  efd_cfg_regs u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .range_type  (range_type),
    .max_payload (max_payload)
  );

  // held byte moves on unless it makes a result that has nowhere to go
  assign advance  = hold_valid && (!emit || !out_valid || out_ready);
  assign in_ready = !hold_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_byte <= in_byte;
    end
  end

  // frame state and field decode
  efd_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .data_byte   (hold_byte),
    .range_type  (range_type),
    .max_payload (max_payload),
    .emit        (emit),
    .result      (result)
  );

  // result register
  efd_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && emit),
    .load_data (result),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  assign status      = out_data.status;
  assign timestamp   = out_data.timestamp;
  assign event_type  = out_data.event_type;
  assign range_value = out_data.range_value;
  assign range_count = out_data.range_count;

endmodule

// ===== verif/event_frame_deframer_top_tb.sv =====
module event_frame_deframer_top_tb;

  // sync byte that opens every frame
  localparam logic [7:0] SYNC_BYTE = 8'h45;
  // cycles to let pass after the last expected record, covers a held byte
  localparam int SETTLE_CYCLES = 8;
  // cap on waiting for outstanding records
  localparam int DRAIN_LIMIT = 5000;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2
  } frame_phase_t;

  typedef logic [7:0] byte_seq_t[$];

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;

  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [7:0]                    in_byte = 8'h00;

  logic                          out_valid;
  logic                          out_ready = 1'b1;
  logic [1:0]                    status;
  logic [31:0]                   timestamp;
  logic [7:0]                    event_type;
  logic [15:0]                   range_value;
  logic [7:0]                    range_count;

  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [efd_pkg::AddrWidth-1:0] paddr = '0;
  logic [31:0]                   pwdata = '0;
  logic [31:0]                   prdata;
  logic                          pready;

  event_frame_deframer_top u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .timestamp   (timestamp),
    .event_type  (event_type),
    .range_value (range_value),
    .range_count (range_count),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #1 clk = ~clk;

  // predicted register contents, same reset values as the block
  logic [7:0]   cfg_range_type = 8'd1;
  logic [7:0]   cfg_max_payload = 8'd12;

  // predicted frame state
  frame_phase_t fr_phase = PH_HUNT;
  logic [7:0]   fr_len = '0;
  logic [7:0]   fr_pos = '0;
  logic [31:0]  fr_stamp = '0;
  logic [7:0]   fr_type = '0;
  logic [15:0]  fr_range = '0;
  logic [7:0]   fr_count = '0;

  // decoded records still to come out of the block, oldest first
  efd_pkg::efd_result_t expected_records[$];

  int           fail_count = 0;
  int           bytes_sent = 0;
  // local copy of in_valid, since reading in_valid shows the pre-edge value
  logic         byte_offered = 1'b0;
  bit           sender_gaps = 1'b1;
  bit           receiver_stalls = 1'b1;
  int           stall_left = 0;

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  // predictor: advances the frame state by one received byte and queues
  // the decoded record when the byte closes a frame
  function automatic void deframe_byte(input logic [7:0] b);
    efd_pkg::efd_result_t rec;
    logic                 is_range;
    rec = '0;
    case (fr_phase)
      PH_LEN: begin
        if (b > cfg_max_payload) begin
          // length too long, reported right away
          rec.status = efd_pkg::ST_LONG;
          expected_records.push_back(rec);
          fr_phase = PH_HUNT;
        end else if (b == 8'd0) begin
          // empty frame counts as truncated
          rec.status = efd_pkg::ST_TRUNC;
          expected_records.push_back(rec);
          fr_phase = PH_HUNT;
        end else begin
          fr_len = b;
          fr_pos = '0;
          fr_stamp = '0;
          fr_type = '0;
          fr_range = '0;
          fr_count = '0;
          fr_phase = PH_DATA;
        end
      end
      PH_DATA: begin
        // little-endian timestamp, then type, then range and count
        if (fr_pos < 8'd4) fr_stamp[8*fr_pos[1:0] +: 8] = b;
        else if (fr_pos == 8'd4) fr_type = b;
        else if (fr_type == cfg_range_type) begin
          if (fr_pos == 8'd5) fr_range[7:0] = b;
          else if (fr_pos == 8'd6) fr_range[15:8] = b;
          else if (fr_pos == 8'd7) fr_count = b;
        end
        fr_pos = fr_pos + 8'd1;
        if (fr_pos == fr_len) begin
          fr_phase = PH_HUNT;
          // range type is taken from the register as it is now
          is_range = (fr_type == cfg_range_type);
          if (fr_len < 8'd5 || (is_range && fr_len < 8'd8)) begin
            rec.status = efd_pkg::ST_TRUNC;
          end else begin
            rec.status = efd_pkg::ST_OK;
            rec.timestamp = fr_stamp;
            rec.event_type = fr_type;
            if (is_range) begin
              rec.range_value = fr_range;
              rec.range_count = fr_count;
            end
          end
          expected_records.push_back(rec);
        end
      end
      default: fr_phase = (b == SYNC_BYTE) ? PH_LEN : PH_HUNT;
    endcase
  endfunction

  // record checker: every accepted result against the oldest prediction
  always @(posedge clk) begin
    efd_pkg::efd_result_t got;
    efd_pkg::efd_result_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      got = '{status, timestamp, event_type, range_value, range_count};
      if (expected_records.size() == 0) begin
        note_failure($sformatf("unexpected record st=%0d ts=%h ty=%h rv=%h rc=%h",
                               got.status, got.timestamp, got.event_type,
                               got.range_value, got.range_count));
      end else begin
        want = expected_records.pop_front();
        if (got.status !== want.status || got.timestamp !== want.timestamp ||
            got.event_type !== want.event_type ||
            got.range_value !== want.range_value ||
            got.range_count !== want.range_count) begin
          note_failure($sformatf({"record mismatch: expected st=%0d ts=%h ty=%h rv=%h rc=%h,",
                                  " got st=%0d ts=%h ty=%h rv=%h rc=%h"},
                                 want.status, want.timestamp, want.event_type,
                                 want.range_value, want.range_count,
                                 got.status, got.timestamp, got.event_type,
                                 got.range_value, got.range_count));
        end
      end
    end
  end

  // receiver side: random stall bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (receiver_stalls && $urandom_range(0, 9) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 11);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // offers one byte, with an occasional gap first, and waits for the handshake
  task automatic send_byte(input logic [7:0] b);
    if (sender_gaps && $urandom_range(0, 7) == 0) begin
      if (byte_offered) begin
        in_valid <= 1'b0;
        byte_offered = 1'b0;
      end
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    byte_offered = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    deframe_byte(b);
  endtask

  task automatic send_bytes(input byte_seq_t seq);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // stop offering, wait for every outstanding record, then let the pipe settle
  task automatic wait_idle();
    int guard;
    guard = 0;
    if (byte_offered) begin
      in_valid <= 1'b0;
      byte_offered = 1'b0;
    end
    while (expected_records.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    if (expected_records.size() != 0) begin
      note_failure($sformatf("%0d records never came out", expected_records.size()));
      expected_records.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // apb write followed by a read back of the same register
  task automatic write_cfg(input logic idx, input logic [7:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'h0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == efd_pkg::REG_RANGE_TYPE) cfg_range_type = val;
    else cfg_max_payload = val;
    // read phase starts straight away, psel stays high
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== {24'h0, val})
      note_failure($sformatf("register %0d read back %h, expected %h", idx, prdata, val));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // frame length for random traffic: mostly small legal, some empty or too long
  function automatic int pick_length();
    int r;
    int top;
    r = $urandom_range(0, 19);
    top = (cfg_max_payload < 8'd12) ? int'(cfg_max_payload) : 12;
    if (r == 0 || (top == 0 && r < 8)) pick_length = 0;
    else if ((r == 1 || top == 0) && cfg_max_payload != 8'hFF)
      pick_length = $urandom_range(int'(cfg_max_payload) + 1, 255);
    else pick_length = $urandom_range(1, top);
  endfunction

  // one framed record; payload stops after keep bytes for a broken frame
  task automatic send_frame(input int len, input int keep);
    logic [7:0] ty;
    ty = ($urandom_range(0, 2) != 0) ? cfg_range_type : 8'($urandom);
    send_byte(SYNC_BYTE);
    send_byte(8'(len));
    if (len >= 1 && len <= int'(cfg_max_payload))
      for (int i = 0; i < len && i < keep; i++) send_byte((i == 4) ? ty : 8'($urandom));
  endtask

  // one traffic phase under a given register setting
  task automatic run_traffic(input logic [7:0] rt, input logic [7:0] mp, input int n_bytes);
    int start;
    int len;
    wait_idle();
    write_cfg(efd_pkg::REG_RANGE_TYPE, rt);
    write_cfg(efd_pkg::REG_MAX_PAYLOAD, mp);
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      // line noise between frames, may itself hold a sync byte
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      len = pick_length();
      if ($urandom_range(0, 19) == 0) send_frame(len, $urandom_range(0, len));
      else send_frame(len, len);
    end
  endtask

  // empty frame, length just above the reset limit, range frame too short
  task automatic test_short_frames();
    send_bytes('{SYNC_BYTE, 8'd0});
    send_bytes('{SYNC_BYTE, 8'd13});
    send_bytes('{SYNC_BYTE, 8'd6, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'hAA});
  endtask

  // all-ones range record under reset settings, then a non-range record
  task automatic test_field_extremes();
    send_bytes('{SYNC_BYTE, 8'd8, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h01, 8'hFF, 8'hFF, 8'hFF});
    send_bytes('{SYNC_BYTE, 8'd5, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF});
  endtask

  // length equal to the limit, and range_type rewritten in the middle of a frame
  task automatic test_mid_frame_type_change();
    wait_idle();
    write_cfg(efd_pkg::REG_MAX_PAYLOAD, 8'd8);
    send_bytes('{SYNC_BYTE, 8'd8, 8'h78, 8'h56, 8'h34, 8'h12, 8'h07});
    // frame is half done here; the new type code applies to the range bytes
    wait_idle();
    write_cfg(efd_pkg::REG_RANGE_TYPE, 8'h07);
    send_bytes('{8'hCD, 8'hAB, 8'h5A});
  endtask

  // random traffic across several register settings, extremes included
  task automatic test_random_traffic();
    run_traffic(8'($urandom), 8'd12, 250);
    run_traffic(8'h00, 8'h00, 60);
    run_traffic(8'hFF, 8'hFF, 300);
    // longest possible frame, once
    send_frame(255, 255);
    run_traffic(8'($urandom_range(0, 3)), 8'($urandom_range(5, 20)), 250);
    // last stretch without any idling
    wait_idle();
    sender_gaps = 1'b0;
    receiver_stalls = 1'b0;
    run_traffic(8'd1, 8'd12, 200);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_short_frames();
    test_field_extremes();
    test_mid_frame_type_change();
    test_random_traffic();
    wait_idle();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // hard stop in case a handshake never completes
  initial begin
    #1000000;
    $display("FAIL");
    $finish;
  end

endmodule
